/* rtl/core/taylor_series_elementary_function_assert.svh */
// assertion macros shared by the checker
`ifndef TAYLOR_SERIES_ELEMENTARY_FUNCTION_ASSERT_SVH
`define TAYLOR_SERIES_ELEMENTARY_FUNCTION_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define TSEF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication outside reset
`define TSEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tsef_pkg.sv */
`timescale 1ns / 1ps
package tsef_pkg;

  localparam int unsigned FracBitsDef = 32;
  localparam int unsigned XFrac       = 28;
  localparam int unsigned WordW       = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned MaxTermsW   = 7;
  localparam int unsigned LnTermsW    = 14;
  localparam int unsigned TolW        = 16;
  localparam int unsigned ResultW     = 48;

  localparam logic [CfgIdxW-1:0] CfgMaxTerms = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLnTerms  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTol      = 2'd2;

  localparam logic [1:0] FuncExp = 2'd0;
  localparam logic [1:0] FuncSin = 2'd1;
  localparam logic [1:0] FuncCos = 2'd2;
  localparam logic [1:0] FuncLn  = 2'd3;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatDomain = 2'd1;
  localparam logic [1:0] StatSat    = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x;
  } req_t;

  typedef struct packed {
    logic signed [ResultW-1:0] result;
    logic [1:0]                status;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone, OpInit, OpRecipStep, OpLnInit, OpMulX, OpMulT, OpDivStart,
    OpDivStep, OpAcc, OpLnAcc, OpFinish
  } op_e;

  // part: partial product step of a multiply, 0 to 3, then 4 writes the product
  typedef struct packed {
    op_e              op;
    logic [13:0]      idx;
    logic [2:0]       part;
  } cmd_t;

  typedef struct packed {
    logic small_term;
    logic ln_domain;
    logic ln_ge_one;
  } stat_t;

endpackage

/* rtl/core/taylor_series_elementary_function.sv */
`timescale 1ns / 1ps
// channel  | signals                       | direction
// request  | in_valid_i, in_stall_o, in_i  | in
// response | out_valid_o, out_stall_i, out_o | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i | in
// one request at a time; a multiply runs its partial products on a shared 32x32 multiplier
// and a 64-step radix-2 divider follows; a term takes one multiply for exp and two for
// sin/cos; ln runs a 60-step reciprocal first (also on a domain error) and then one
// multiply per ln term.
// reset is asynchronous active low and restores the register defaults.
// the result register holds while out_stall_i is high; no new request is taken then.
module taylor_series_elementary_function #(
  parameter int unsigned FracBits = tsef_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tsef_pkg::req_t                 in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tsef_pkg::rsp_t                 out_o,
  input  logic                           cfg_we_i,
  input  logic [tsef_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsef_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tsef_pkg::*;

  logic [MaxTermsW-1:0] max_terms_q;
  logic [LnTermsW-1:0]  ln_terms_q;
  logic [TolW-1:0]      tol_q;
  logic                 load;
  cmd_t                 cmd;
  stat_t                stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_terms_q <= 7'd32; ln_terms_q <= 14'd9999; tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxTerms: max_terms_q <= cfg_data_i[MaxTermsW-1:0];
        CfgLnTerms:  ln_terms_q  <= cfg_data_i[LnTermsW-1:0];
        CfgTol:      tol_q       <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  tsef_ctrl #(.FracBits(FracBits)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i(in_i.func), .load_o(load),
    .out_valid_o, .out_stall_i, .max_terms_i(max_terms_q), .ln_terms_i(ln_terms_q),
    .stat_i(stat), .cmd_o(cmd)
  );

  tsef_datapath #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .req_i(in_i), .load_i(load), .cmd_i(cmd), .tol_i(tol_q),
    .stat_o(stat), .rsp_o(out_o)
  );
endmodule

/* rtl/core/tsef_datapath.sv */
`timescale 1ns / 1ps
module tsef_datapath #(
  parameter int unsigned FracBits = tsef_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsef_pkg::req_t                req_i,
  input  logic                          load_i,
  input  tsef_pkg::cmd_t                cmd_i,
  input  logic [tsef_pkg::TolW-1:0]     tol_i,
  output tsef_pkg::stat_t               stat_o,
  output tsef_pkg::rsp_t                rsp_o
);
  import tsef_pkg::*;

  localparam logic [62:0] IntLim = {1'b0, {62{1'b1}}};
  localparam int unsigned RecipBits = FracBits + XFrac;

  logic [1:0]         func_q;
  logic signed [31:0] x_q;
  logic [62:0]        term_mag_q, term_mag_d;
  logic               term_neg_q, term_neg_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [63:0] t_q, t_d;
  logic               flip_q, flip_d;
  logic [63:0]        rq_q, rq_d;
  logic [64:0]        rr_q, rr_d;
  logic [62:0]        pw_mag_q, pw_mag_d;
  logic               pw_neg_q, pw_neg_d;
  logic [63:0]        dq_q, dq_d;
  logic [63:0]        drem_q, drem_d;
  logic [28:0]        dden_q, dden_d;
  logic [127:0]       prod_q, prod_d;
  rsp_t               rsp_q, rsp_d;

  logic [31:0]  x_mag;
  logic [63:0]  t_mag;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [31:0]  pp_a;
  logic [31:0]  pp_b;
  logic [63:0]  pp;
  logic [6:0]   pp_shift;
  logic [127:0] pp_sh;
  logic [127:0] prod_sh;
  int unsigned  mul_s;
  logic [63:0]  mul_sat;
  logic [64:0]  rr_sh;
  logic [64:0]  drem_sh;
  logic signed [64:0] acc_w;
  logic signed [63:0] acc_sat;
  logic signed [63:0] addend;
  logic [28:0]  den;
  logic signed [63:0] x_frac;
  logic signed [63:0] fin;

  assign x_mag = x_q[31] ? (32'd0 - x_q) : x_q;
  assign t_mag = t_q[63] ? (64'd0 - t_q) : t_q;

  // x in the working fraction format
  always_comb begin
    if (FracBits >= XFrac) begin
      x_frac = 64'(signed'(x_q)) <<< (FracBits - XFrac);
    end else begin
      x_frac = x_q[31] ? -$signed({32'd0, x_mag >> (XFrac - FracBits)})
                       : $signed({32'd0, x_mag >> (XFrac - FracBits)});
    end
  end

  // shared 32x32 multiplier: one partial product per step, then scale and clamp
  always_comb begin
    if (cmd_i.op == OpMulT) begin
      mul_a = {1'b0, pw_mag_q};
      mul_b = t_mag;
      mul_s = FracBits;
    end else begin
      mul_a = {1'b0, term_mag_q};
      mul_b = {32'd0, x_mag};
      mul_s = XFrac;
    end
    pp_a     = cmd_i.part[0] ? mul_a[63:32] : mul_a[31:0];
    pp_b     = cmd_i.part[1] ? mul_b[63:32] : mul_b[31:0];
    pp       = {32'd0, pp_a} * {32'd0, pp_b};
    pp_shift = {cmd_i.part[1] & cmd_i.part[0], cmd_i.part[1] ^ cmd_i.part[0], 5'd0};
    pp_sh    = {64'd0, pp} << pp_shift;
    prod_sh  = prod_q >> mul_s;
    mul_sat  = (prod_sh[127:62] != '0) ? {1'b0, IntLim} : {1'b0, prod_sh[62:0]};
  end

  // divisor for the current term
  always_comb begin
    case (func_q)
      FuncSin: den = 29'(({15'd0, cmd_i.idx} << 1) * (({15'd0, cmd_i.idx} << 1) + 29'd1));
      FuncCos: den = 29'(({15'd0, cmd_i.idx} << 1) * (({15'd0, cmd_i.idx} << 1) - 29'd1));
      default: den = {15'd0, cmd_i.idx};
    endcase
  end

  assign rr_sh   = {rr_q[63:0], 1'b0};
  assign drem_sh = {drem_q, dq_q[63]};

  always_comb begin
    if (cmd_i.op == OpLnAcc) begin
      addend = (cmd_i.idx[0] ^ pw_neg_q) ? $signed({1'b0, dq_q[62:0]})
                                         : -$signed({1'b0, dq_q[62:0]});
    end else begin
      addend = term_neg_q ? -$signed({1'b0, dq_q[62:0]}) : $signed({1'b0, dq_q[62:0]});
    end
    acc_w = 65'(sum_q) + 65'(addend);
    if (acc_w > 65'sd4611686018427387903) acc_sat = $signed({1'b0, IntLim});
    else if (acc_w < -65'sd4611686018427387903) acc_sat = -$signed({1'b0, IntLim});
    else acc_sat = acc_w[63:0];
  end

  always_comb begin
    fin = flip_q ? -sum_q : sum_q;
  end

  // datapath register updates
  always_comb begin
    term_mag_d = term_mag_q; term_neg_d = term_neg_q; sum_d = sum_q; t_d = t_q;
    flip_d = flip_q; rq_d = rq_q; rr_d = rr_q; pw_mag_d = pw_mag_q;
    pw_neg_d = pw_neg_q; dq_d = dq_q; drem_d = drem_q; dden_d = dden_q; rsp_d = rsp_q;
    prod_d = prod_q;
    case (cmd_i.op)
      OpInit: begin
        flip_d = 1'b0;
        if (func_q == FuncSin) begin
          term_mag_d = x_frac[63] ? 63'(-x_frac) : x_frac[62:0];
          term_neg_d = x_frac[63];
          sum_d = x_frac;
        end else begin
          term_mag_d = 63'(64'd1 << FracBits);
          term_neg_d = 1'b0;
          sum_d = 64'sd1 <<< FracBits;
        end
        rq_d = '0; rr_d = 65'd1;
      end
      OpRecipStep: begin
        if (rr_sh >= {33'd0, x_q}) begin
          rr_d = rr_sh - {33'd0, x_q}; rq_d = {rq_q[62:0], 1'b1};
        end else begin
          rr_d = rr_sh; rq_d = {rq_q[62:0], 1'b0};
        end
      end
      OpLnInit: begin
        if (x_q >= (32'sd1 <<< XFrac)) begin
          t_d = $signed(rq_q) - (64'sd1 <<< FracBits); flip_d = 1'b1;
        end else begin
          t_d = x_frac - (64'sd1 <<< FracBits);
        end
        pw_mag_d = 63'(64'd1 << FracBits); pw_neg_d = 1'b0; sum_d = '0;
      end
      OpMulX: begin
        if (cmd_i.part == 3'd4) begin
          term_mag_d = mul_sat[62:0]; term_neg_d = term_neg_q ^ x_q[31];
        end else begin
          prod_d = (cmd_i.part == 3'd0) ? pp_sh : (prod_q + pp_sh);
        end
      end
      OpMulT: begin
        if (cmd_i.part == 3'd4) begin
          pw_mag_d = mul_sat[62:0]; pw_neg_d = pw_neg_q ^ t_q[63];
        end else begin
          prod_d = (cmd_i.part == 3'd0) ? pp_sh : (prod_q + pp_sh);
        end
      end
      OpDivStart: begin
        dq_d = {1'b0, (func_q == FuncLn) ? pw_mag_q : term_mag_q};
        drem_d = '0;
        dden_d = (den == '0) ? 29'd1 : den;
        if (func_q == FuncSin || func_q == FuncCos) term_neg_d = ~term_neg_q;
      end
      OpDivStep: begin
        if (drem_sh >= {36'd0, dden_q}) begin
          drem_d = 64'(drem_sh - {36'd0, dden_q}); dq_d = {dq_q[62:0], 1'b1};
        end else begin
          drem_d = drem_sh[63:0]; dq_d = {dq_q[62:0], 1'b0};
        end
      end
      OpAcc: begin
        if (func_q != FuncLn) term_mag_d = dq_q[62:0];
        sum_d = acc_sat;
      end
      OpLnAcc: sum_d = acc_sat;
      OpFinish: begin
        rsp_d.status = StatOk;
        if (func_q == FuncLn && x_q <= 0) begin
          rsp_d.result = '0; rsp_d.status = StatDomain;
        end else if (fin > $signed({{(WordW-ResultW+1){1'b0}}, {(ResultW-1){1'b1}}})) begin
          rsp_d.result = {1'b0, {(ResultW-1){1'b1}}}; rsp_d.status = StatSat;
        end else if (fin < -$signed({{(WordW-ResultW+1){1'b0}}, {(ResultW-1){1'b1}}}) - 64'sd1) begin
          rsp_d.result = {1'b1, {(ResultW-1){1'b0}}}; rsp_d.status = StatSat;
        end else begin
          rsp_d.result = fin[ResultW-1:0];
        end
      end
      default: ;
    endcase
  end

  // quotient is the new term: check it against tolerance
  assign stat_o.small_term = (dq_q[62:0] < {47'd0, tol_i});
  assign stat_o.ln_domain  = (x_q <= 0);
  assign stat_o.ln_ge_one  = (x_q >= (32'sd1 <<< XFrac));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      func_q <= req_i.func; x_q <= req_i.x;
    end
    term_mag_q <= term_mag_d; term_neg_q <= term_neg_d; sum_q <= sum_d; t_q <= t_d;
    flip_q <= flip_d; rq_q <= rq_d; rr_q <= rr_d; pw_mag_q <= pw_mag_d;
    pw_neg_q <= pw_neg_d; dq_q <= dq_d; drem_q <= drem_d; dden_q <= dden_d;
    prod_q <= prod_d; rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  logic unused;
  assign unused = rst_ni ^ (RecipBits == 0);
endmodule

/* rtl/core/tsef_ctrl.sv */
`timescale 1ns / 1ps
module tsef_ctrl #(
  parameter int unsigned FracBits = tsef_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  output logic                           load_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [tsef_pkg::MaxTermsW-1:0] max_terms_i,
  input  logic [tsef_pkg::LnTermsW-1:0]  ln_terms_i,
  input  tsef_pkg::stat_t                stat_i,
  output tsef_pkg::cmd_t                 cmd_o
);
  import tsef_pkg::*;

  localparam int unsigned RecipSteps = FracBits + XFrac;

  typedef enum logic [3:0] {
    SIdle, SInit, SRecip, SLnInit, SMul1, SMul2, SDivStart, SDiv, SChk,
    SFinish, SOut
  } state_e;

  state_e      state_q;
  logic [1:0]  func_q;
  logic [13:0] idx_q;
  logic [6:0]  cnt_q;
  logic        out_valid_q;

  // issued operation follows the state
  always_comb begin
    cmd_o.idx  = idx_q;
    cmd_o.part = cnt_q[2:0];
    case (state_q)
      SInit:     cmd_o.op = OpInit;
      SRecip:    cmd_o.op = OpRecipStep;
      SLnInit:   cmd_o.op = OpLnInit;
      SMul1:     cmd_o.op = (func_q == FuncLn) ? OpMulT : OpMulX;
      SMul2:     cmd_o.op = OpMulX;
      SDivStart: cmd_o.op = OpDivStart;
      SDiv:      cmd_o.op = OpDivStep;
      SChk:      cmd_o.op = (func_q == FuncLn) ? OpLnAcc :
                            (stat_i.small_term ? OpNone : OpAcc);
      SFinish:   cmd_o.op = OpFinish;
      default:   cmd_o.op = OpNone;
    endcase
  end

  assign in_stall_o  = (state_q != SIdle);
  assign load_o      = in_valid_i && (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; func_q <= FuncExp; idx_q <= '0; cnt_q <= '0; out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (in_valid_i) begin
          func_q <= func_i; idx_q <= 14'd1; state_q <= SInit;
        end
        SInit: begin
          if (func_q == FuncLn) begin
            cnt_q <= '0; state_q <= SRecip;
          end else if (max_terms_i <= 7'd1) begin
            state_q <= SFinish;
          end else begin
            cnt_q <= '0; state_q <= SMul1;
          end
        end
        SRecip: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(RecipSteps - 1)) state_q <= SLnInit;
        end
        SLnInit: begin
          cnt_q <= '0;
          if (stat_i.ln_domain || ln_terms_i == '0) state_q <= SFinish;
          else state_q <= SMul1;
        end
        // four partial products, then the product write
        SMul1: begin
          if (cnt_q == 7'd4) begin
            cnt_q <= '0;
            state_q <= (func_q == FuncSin || func_q == FuncCos) ? SMul2 : SDivStart;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        SMul2: begin
          if (cnt_q == 7'd4) begin
            cnt_q <= '0; state_q <= SDivStart;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        SDivStart: begin
          cnt_q <= '0; state_q <= SDiv;
        end
        SDiv: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_q <= SChk;
        end
        SChk: begin
          idx_q <= idx_q + 14'd1;
          cnt_q <= '0;
          if (func_q == FuncLn) begin
            state_q <= (idx_q >= ln_terms_i) ? SFinish : SMul1;
          end else if (stat_i.small_term || ({7'd0, idx_q[6:0]} + 14'd1 >= {7'd0, max_terms_i})
                       || idx_q[13:7] != '0) begin
            state_q <= SFinish;
          end else begin
            state_q <= SMul1;
          end
        end
        SFinish: begin
          out_valid_q <= 1'b1; state_q <= SOut;
        end
        SOut: if (!out_stall_i) begin
          out_valid_q <= 1'b0; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

/* rtl/core/tsef_checker.sv */
`timescale 1ns / 1ps
`include "taylor_series_elementary_function_assert.svh"
module tsef_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tsef_pkg::rsp_t out_o
);
  import tsef_pkg::*;

  `TSEF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "stalled response changed")
  `TSEF_ASSERT_IMPL(a_busy_when_out, clk_i, rst_ni, out_valid_o, in_stall_o, "request taken while response pending")
  `TSEF_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, out_o.status != 2'd3, "bad status code")
  `TSEF_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !out_valid_o, "accept did not start work")
endmodule

bind taylor_series_elementary_function tsef_checker u_chk (.*);

/* verif/taylor_series_elementary_function_test.sv */
`timescale 1ns / 1ps
module taylor_series_elementary_function_test;
  import tsef_pkg::*;

  localparam longint SatLim = (longint'(1) << 62) - 1;
  localparam longint OutMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint OutMin = -OutMax - 1;
  localparam longint One    = longint'(1) << FracBitsDef;

  // predicts each series result and checks responses in order
  class series_checker;
    rsp_t        expected_values[$];
    int unsigned failures;
    bit [6:0]    max_terms;
    bit [13:0]   ln_terms;
    bit [15:0]   tolerance;

    function new();
      failures  = 0;
      max_terms = 7'd32;
      ln_terms  = 14'd9999;
      tolerance = 16'd1;
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint signed_clamp(bit [63:0] m, bit neg);
      if (m > 64'(SatLim)) m = 64'(SatLim);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint fx_mul(longint a, longint b, int s);
      bit [127:0] p;
      p = ({64'b0, mag(a)} * {64'b0, mag(b)}) >> s;
      if (p[127:64] != 0) return signed_clamp({64{1'b1}}, (a < 0) != (b < 0));
      return signed_clamp(p[63:0], (a < 0) != (b < 0));
    endfunction

    function longint fx_div(longint a, bit [63:0] d);
      if (d == 0) d = 1;
      return signed_clamp(mag(a) / d, a < 0);
    endfunction

    function longint fx_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SatLim) s = SatLim;
      if (s < -SatLim) s = -SatLim;
      return s;
    endfunction

    // value of the selected series before output clamping
    function longint series_value(logic [1:0] fn, longint xq);
      longint term, sum, t, p;
      bit [63:0] d;
      bit flip;
      sum = 0;
      if (fn == FuncExp) begin
        sum = One;
        term = One;
        for (int unsigned i = 1; i < max_terms; i++) begin
          term = fx_div(fx_mul(term, xq, XFrac), i);
          if (mag(term) < tolerance) break;
          sum = fx_add(sum, term);
        end
      end else if (fn == FuncSin || fn == FuncCos) begin
        term = (fn == FuncCos) ? One : (xq <<< (FracBitsDef - XFrac));
        sum = term;
        for (int unsigned i = 1; i < max_terms; i++) begin
          d = (fn == FuncCos) ? 64'(2 * i - 1) * 64'(2 * i) : 64'(2 * i) * 64'(2 * i + 1);
          term = fx_mul(fx_mul(term, xq, XFrac), xq, XFrac);
          term = -fx_div(term, d);
          if (mag(term) < tolerance) break;
          sum = fx_add(sum, term);
        end
      end else begin
        // ln: x >= 1 goes through the reciprocal
        flip = xq >= (longint'(1) << XFrac);
        if (flip) t = longint'((64'd1 << (FracBitsDef + XFrac)) / 64'(xq)) - One;
        else t = (xq <<< (FracBitsDef - XFrac)) - One;
        p = One;
        for (int unsigned i = 1; i <= ln_terms; i++) begin
          p = fx_mul(p, t, FracBitsDef);
          term = fx_div(p, i);
          sum = fx_add(sum, i[0] ? term : -term);
        end
        if (flip) sum = -sum;
      end
      return sum;
    endfunction

    function void note_request(req_t req);
      longint xq, v;
      rsp_t r;
      xq = {{32{req.x[31]}}, req.x};
      r.status = StatOk;
      if (req.func == FuncLn && xq <= 0) begin
        v = 0;
        r.status = StatDomain;
      end else begin
        v = series_value(req.func, xq);
      end
      if (v > OutMax) begin
        v = OutMax;
        r.status = StatSat;
      end else if (v < OutMin) begin
        v = OutMin;
        r.status = StatSat;
      end
      r.result = v[ResultW-1:0];
      expected_values.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected response result=%h status=%0d", $time, got.result, got.status);
        failures++;
        return;
      end
      e = expected_values.pop_front();
      if (got.result !== e.result) begin
        $display("%0t: result mismatch expected=%h actual=%h", $time, e.result, got.result);
        failures++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, got.status);
        failures++;
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  req_t                in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rsp_t                out_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  series_checker chk = new();
  bit quiet;
  bit hold_req;

  taylor_series_elementary_function u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_response(out_o);
  end

  // receiver stalls: random bursts, one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    #600_000_000;
    $display("taylor_series_elementary_function regression: fail");
    $finish;
  end

  task automatic send_request(logic [1:0] fn, logic [31:0] x);
    req_t req;
    req.func = fn;
    req.x = x;
    in_i <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_request(req);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMaxTerms) chk.max_terms = data[6:0];
    else if (idx == CfgLnTerms) chk.ln_terms = data[13:0];
    else if (idx == CfgTol) chk.tolerance = data;
  endtask

  task automatic set_regs(int mt, int lt, int tol);
    write_reg(CfgMaxTerms, CfgDataW'(mt));
    write_reg(CfgLnTerms, CfgDataW'(lt));
    write_reg(CfgTol, CfgDataW'(tol));
  endtask

  // random argument: mostly moderate, some full range, some near one
  function automatic logic [31:0] pick_x(logic [1:0] fn);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
      2: return 32'h1000_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
      default: return (fn == FuncLn) ? {1'b0, 31'($urandom)} : 32'($urandom_range(0, 32'h3FFF_FFFF));
    endcase
  endfunction

  initial begin
    logic [1:0] fn;
    int mt, lt, tol;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: argument extremes and ln domain errors
    send_request(FuncExp, 32'h0000_0000);
    send_request(FuncExp, 32'h1000_0000);
    send_request(FuncExp, 32'h7FFF_FFFF);
    send_request(FuncExp, 32'h8000_0000);
    send_request(FuncSin, 32'h7FFF_FFFF);
    send_request(FuncSin, 32'h8000_0000);
    send_request(FuncSin, 32'h0800_0000);
    send_request(FuncCos, 32'h0000_0000);
    send_request(FuncCos, 32'hF000_0000);
    send_request(FuncLn, 32'h0000_0000);
    send_request(FuncLn, 32'h8000_0000);
    send_request(FuncLn, 32'hFFFF_FFFF);
    drain();

    // 64 terms, no early stop, single ln term
    set_regs(64, 1, 0);
    send_request(FuncExp, 32'h7FFF_FFFF);
    send_request(FuncSin, 32'h7FFF_FFFF);
    send_request(FuncCos, 32'h8000_0000);
    send_request(FuncLn, 32'h1000_0000);
    send_request(FuncLn, 32'h7FFF_FFFF);
    send_request(FuncLn, 32'h0000_0001);
    drain();

    // zero and one term limits, widest tolerance
    set_regs(0, 0, 65535);
    send_request(FuncExp, 32'h2000_0000);
    send_request(FuncCos, 32'h2000_0000);
    send_request(FuncLn, 32'h1800_0000);
    drain();
    set_regs(1, 7, 1);
    send_request(FuncSin, 32'h3000_0000);
    send_request(FuncLn, 32'h0400_0000);
    drain();

    // longest ln series, once
    set_regs(8, 16383, 1);
    send_request(FuncLn, 32'h1800_0000);
    drain();

    // random phases with random register settings
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: mt = 0;
        1: mt = 1;
        2: mt = 64;
        default: mt = $urandom_range(2, 20);
      endcase
      lt = $urandom_range(0, 40);
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = 1;
        2: tol = 65535;
        default: tol = $urandom_range(0, 65535);
      endcase
      set_regs(mt, lt, tol);
      quiet = (ph == 7);
      for (int n = 0; n < 235; n++) begin
        if (ph == 2 && n == 20) hold_req = 1'b1;
        fn = 2'($urandom_range(0, 3));
        send_request(fn, pick_x(fn));
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (chk.failures == 0 && chk.pending() == 0)
      $display("taylor_series_elementary_function regression: pass");
    else
      $display("taylor_series_elementary_function regression: fail");
    $finish;
  end
endmodule
